/* hw/rtl/cpbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpbp_pkg
// Shared types, constants and helpers for the chained packet buffer pool.
// ----------------------------------------------------------------------------
package cpbp_pkg;

  // Pool geometry
  localparam int unsigned SLOT_COUNT  = 64;
  localparam int unsigned SLOT_SIZE   = 32;
  localparam int unsigned CHAIN_COUNT = 16;

  localparam int unsigned SLOT_W  = 7;   // slot number incl. nil code
  localparam int unsigned SIDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned FILL_W  = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 7;   // free count, walk steps
  localparam int unsigned HDL_W   = 4;
  localparam int unsigned BYTE_AW = $clog2(SLOT_COUNT * SLOT_SIZE);

  localparam logic [SLOT_W-1:0] NIL_SLOT = 7'd127;
  localparam logic [BYTE_W-1:0] REF_MAX  = 8'd255;
  localparam logic [BYTE_W-1:0] TOT_MAX  = 8'd255;

  // Operation codes
  typedef enum logic [2:0] {
    FN_NEW         = 3'd0,
    FN_RELEASE     = 3'd1,
    FN_NEW_REF     = 3'd2,
    FN_RESET       = 3'd3,
    FN_SEEK        = 3'd4,
    FN_PUT         = 3'd5,
    FN_GET         = 3'd6,
    FN_REMOVE_LAST = 3'd7
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NO_WRITE = 2'd2,
    STS_RANGE    = 2'd3
  } stat_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_EVAL,
    S_RD,
    S_BYTE,
    S_WR2,
    S_DONE
  } state_t;

  // Datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_RD,
    CMD_EVAL,
    CMD_BYTE,
    CMD_WR2,
    CMD_OUT
  } cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic need_rd;   // first slot read needed
    logic more;      // another slot read needed
    logic byte_rd;   // byte memory read needed
    logic wr2;       // second slot record write needed
  } dp_sts_t;

  typedef struct packed {
    logic [BYTE_W-1:0] refs;
    logic [FILL_W-1:0] fill;
    logic [SLOT_W-1:0] link;
  } slot_rec_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] ws;
    logic [SLOT_W-1:0] rs;
    logic [BYTE_W-1:0] off;
    logic [BYTE_W-1:0] tot;
  } desc_t;

  localparam slot_rec_t REC_RST  = '{refs: '0, fill: '0, link: NIL_SLOT};
  localparam desc_t     DESC_RST = '{head: NIL_SLOT, ws: NIL_SLOT, rs: NIL_SLOT,
                                     off: '0, tot: '0};

  function automatic logic slot_real(input logic [SLOT_W-1:0] s);
    return (s != NIL_SLOT) && (s < SLOT_W'(SLOT_COUNT));
  endfunction

  function automatic logic [BYTE_AW-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [BYTE_W-1:0] r);
    return BYTE_AW'(s[SIDX_W-1:0]) * BYTE_AW'(SLOT_SIZE) + BYTE_AW'(r);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/cpbp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpbp_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64,
  localparam int unsigned AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cpbp_ctl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpbp_ctl
// Sequencer: accepts a word, steps the datapath through slot walks and
// memory accesses, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cpbp_ctl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire cpbp_pkg::dp_sts_t sts,
  output cpbp_pkg::cmd_t         cmd
);

  cpbp_pkg::state_t st_r, st_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign in_tready  = (st_r == cpbp_pkg::S_IDLE);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      cpbp_pkg::S_IDLE:   if (in_tvalid) st_nxt = cpbp_pkg::S_DECIDE;
      cpbp_pkg::S_DECIDE: st_nxt = sts.need_rd ? cpbp_pkg::S_EVAL : cpbp_pkg::S_DONE;
      cpbp_pkg::S_EVAL: begin
        priority if (sts.more)    st_nxt = cpbp_pkg::S_RD;
        else if (sts.byte_rd)     st_nxt = cpbp_pkg::S_BYTE;
        else if (sts.wr2)         st_nxt = cpbp_pkg::S_WR2;
        else                      st_nxt = cpbp_pkg::S_DONE;
      end
      cpbp_pkg::S_RD:     st_nxt = cpbp_pkg::S_EVAL;
      cpbp_pkg::S_BYTE:   st_nxt = cpbp_pkg::S_DONE;
      cpbp_pkg::S_WR2:    st_nxt = cpbp_pkg::S_DONE;
      cpbp_pkg::S_DONE:   if (out_free) st_nxt = cpbp_pkg::S_IDLE;
      default:            st_nxt = cpbp_pkg::S_IDLE;
    endcase
  end

  // commands and output valid
  always_comb begin
    cmd            = cpbp_pkg::CMD_NONE;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (st_r)
      cpbp_pkg::S_IDLE:   if (in_tvalid) cmd = cpbp_pkg::CMD_LOAD;
      cpbp_pkg::S_DECIDE: cmd = cpbp_pkg::CMD_EXEC;
      cpbp_pkg::S_EVAL:   cmd = cpbp_pkg::CMD_EVAL;
      cpbp_pkg::S_RD:     cmd = cpbp_pkg::CMD_RD;
      cpbp_pkg::S_BYTE:   cmd = cpbp_pkg::CMD_BYTE;
      cpbp_pkg::S_WR2:    cmd = cpbp_pkg::CMD_WR2;
      cpbp_pkg::S_DONE: begin
        if (out_free) begin
          cmd            = cpbp_pkg::CMD_OUT;
          out_tvalid_nxt = 1'b1;
        end
      end
      default:            cmd = cpbp_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= cpbp_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cpbp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpbp_dp
// Datapath: descriptor table, slot record memory with valid bits, free
// bitmap, byte memory, walk registers and the output register.
// ----------------------------------------------------------------------------
module cpbp_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       in_tdata,
  input  wire cpbp_pkg::cmd_t    cmd,
  output cpbp_pkg::dp_sts_t      sts,
  output logic [31:0]            out_tdata
);

  localparam int unsigned SW = cpbp_pkg::SLOT_W;
  localparam int unsigned IW = cpbp_pkg::SIDX_W;
  localparam int unsigned BW = cpbp_pkg::BYTE_W;

  // latched word
  cpbp_pkg::func_t op_r, op_nxt;
  logic [cpbp_pkg::HDL_W-1:0] c_r, c_nxt, oc_r, oc_nxt;
  logic [BW-1:0] din_r, din_nxt, pos_r, pos_nxt;

  // walk registers
  logic [SW-1:0] cur_s_r, cur_s_nxt, prev_s_r, prev_s_nxt;
  cpbp_pkg::slot_rec_t prev_rec_r, prev_rec_nxt;
  logic [BW-1:0] cur_r_r, cur_r_nxt;
  logic [cpbp_pkg::CNT_W-1:0] steps_r, steps_nxt;
  logic phase_r, phase_nxt;
  cpbp_pkg::stat_t stat_r, stat_nxt;
  logic [IW-1:0] w2_addr_r, w2_addr_nxt;
  cpbp_pkg::slot_rec_t w2_rec_r, w2_rec_nxt;
  logic [31:0] out_r, out_nxt;

  // control state
  cpbp_pkg::desc_t desc_r [cpbp_pkg::CHAIN_COUNT];
  logic [cpbp_pkg::SLOT_COUNT-1:0] vld_r, free_r;
  logic [cpbp_pkg::CNT_W-1:0] unused_r, unused_nxt;
  logic rd_vld_r;

  // memory ports
  logic s_we, s_re;
  logic [IW-1:0] s_waddr, s_raddr;
  cpbp_pkg::slot_rec_t s_wdata, s_rdata, rec;
  logic b_we, b_re;
  logic [cpbp_pkg::BYTE_AW-1:0] b_waddr, b_raddr;
  logic [BW-1:0] b_wdata, b_rdata;

  // descriptor / free bitmap write ports
  logic d_we;
  logic [cpbp_pkg::HDL_W-1:0] d_idx;
  cpbp_pkg::desc_t d_new, dsc;
  logic f_we, f_val;
  logic [IW-1:0] f_idx;

  // helpers
  logic ff_found;
  logic [IW-1:0] ff_idx;
  logic [SW-1:0] ff_slot, start_s;
  logic bad;
  logic [BW-1:0] fill_x, nrefs;
  logic [cpbp_pkg::CNT_W-1:0] steps_inc;
  logic [cpbp_pkg::FILL_W-1:0] nfill;

  cpbp_ram #(.W($bits(cpbp_pkg::slot_rec_t)), .D(cpbp_pkg::SLOT_COUNT)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  cpbp_ram #(.W(BW), .D(cpbp_pkg::SLOT_COUNT * cpbp_pkg::SLOT_SIZE)) u_byte_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  // never-written slot records read as reset value
  assign rec       = rd_vld_r ? s_rdata : cpbp_pkg::REC_RST;
  assign dsc       = desc_r[c_r];
  assign fill_x    = BW'(rec.fill);
  assign steps_inc = steps_r + 1'b1;
  assign ff_slot   = SW'(ff_idx);
  assign out_tdata = out_r;
  assign bad       = ({1'b0, c_r} >= 5'(cpbp_pkg::CHAIN_COUNT)) ||
                     ((op_r == cpbp_pkg::FN_NEW_REF) &&
                      ({1'b0, oc_r} >= 5'(cpbp_pkg::CHAIN_COUNT)));

  // lowest free slot
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = cpbp_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        ff_found = 1'b1;
        ff_idx   = IW'(i);
      end
    end
  end

  // walk start slot
  always_comb begin
    unique case (op_r)
      cpbp_pkg::FN_PUT: start_s = dsc.ws;
      cpbp_pkg::FN_GET: start_s = dsc.rs;
      default:          start_s = dsc.head;
    endcase
  end

  // operation sequencing
  always_comb begin
    op_nxt = op_r; c_nxt = c_r; oc_nxt = oc_r; din_nxt = din_r; pos_nxt = pos_r;
    cur_s_nxt = cur_s_r; prev_s_nxt = prev_s_r; prev_rec_nxt = prev_rec_r;
    cur_r_nxt = cur_r_r; steps_nxt = steps_r; phase_nxt = phase_r;
    stat_nxt = stat_r; w2_addr_nxt = w2_addr_r; w2_rec_nxt = w2_rec_r;
    out_nxt = out_r; unused_nxt = unused_r;
    d_we = 1'b0; d_idx = c_r; d_new = dsc;
    s_we = 1'b0; s_waddr = cur_s_r[IW-1:0]; s_wdata = rec;
    s_re = 1'b0; s_raddr = cur_s_r[IW-1:0];
    f_we = 1'b0; f_idx = cur_s_r[IW-1:0]; f_val = 1'b0;
    b_we = 1'b0; b_waddr = cpbp_pkg::byte_addr(cur_s_r, cur_r_r); b_wdata = din_r;
    b_re = 1'b0; b_raddr = cpbp_pkg::byte_addr(cur_s_r, cur_r_r);
    sts = '0;
    nrefs = rec.refs;
    nfill = rec.fill;

    unique case (cmd)
      cpbp_pkg::CMD_NONE: ;

      cpbp_pkg::CMD_LOAD: begin
        op_nxt    = cpbp_pkg::func_t'(in_tdata[2:0]);
        c_nxt     = in_tdata[6:3];
        oc_nxt    = in_tdata[10:7];
        din_nxt   = in_tdata[18:11];
        pos_nxt   = in_tdata[26:19];
        stat_nxt  = cpbp_pkg::STS_OK;
        steps_nxt = '0;
        phase_nxt = 1'b0;
      end

      // first cycle: one-step operations, or start of a slot walk
      cpbp_pkg::CMD_EXEC: begin
        cur_s_nxt  = start_s;
        prev_s_nxt = start_s;
        if (bad) begin
          stat_nxt = cpbp_pkg::STS_RANGE;
        end else begin
          unique case (op_r)
            cpbp_pkg::FN_NEW: begin
              d_we = 1'b1;
              if (ff_found) begin
                s_we    = 1'b1;
                s_waddr = ff_idx;
                s_wdata = '{refs: 8'd1, fill: '0, link: cpbp_pkg::NIL_SLOT};
                f_we    = 1'b1;
                f_idx   = ff_idx;
                if (unused_r != '0) unused_nxt = unused_r - 1'b1;
                d_new   = '{head: ff_slot, ws: ff_slot, rs: ff_slot, off: '0, tot: '0};
              end else begin
                d_new    = cpbp_pkg::DESC_RST;
                stat_nxt = cpbp_pkg::STS_FULL;
              end
            end
            cpbp_pkg::FN_RELEASE: begin
              if (cpbp_pkg::slot_real(dsc.head)) sts.need_rd = 1'b1;
              else begin
                d_we  = 1'b1;
                d_new = cpbp_pkg::DESC_RST;
              end
            end
            cpbp_pkg::FN_NEW_REF: begin
              if (cpbp_pkg::slot_real(dsc.head)) sts.need_rd = 1'b1;
              else begin
                d_we  = 1'b1;
                d_idx = oc_r;
                d_new = '{head: dsc.head, ws: dsc.ws, rs: dsc.head, off: '0,
                          tot: dsc.tot};
              end
            end
            cpbp_pkg::FN_RESET: begin
              d_we      = 1'b1;
              d_new.rs  = dsc.head;
              d_new.off = '0;
            end
            cpbp_pkg::FN_SEEK: begin
              cur_r_nxt = pos_r;
              if (pos_r > dsc.tot) stat_nxt = cpbp_pkg::STS_RANGE;
              else if (cpbp_pkg::slot_real(dsc.head)) sts.need_rd = 1'b1;
              else begin
                d_we      = 1'b1;
                d_new.rs  = dsc.head;
                d_new.off = pos_r;
              end
            end
            cpbp_pkg::FN_PUT: begin
              if (!cpbp_pkg::slot_real(dsc.ws) || dsc.tot == cpbp_pkg::TOT_MAX)
                stat_nxt = cpbp_pkg::STS_NO_WRITE;
              else sts.need_rd = 1'b1;
            end
            cpbp_pkg::FN_GET: begin
              cur_r_nxt = dsc.off;
              if (cpbp_pkg::slot_real(dsc.rs)) sts.need_rd = 1'b1;
              else stat_nxt = cpbp_pkg::STS_RANGE;
            end
            cpbp_pkg::FN_REMOVE_LAST: begin
              if (cpbp_pkg::slot_real(dsc.head)) sts.need_rd = 1'b1;
              else stat_nxt = cpbp_pkg::STS_RANGE;
            end
          endcase
          if (sts.need_rd) begin
            s_re    = 1'b1;
            s_raddr = start_s[IW-1:0];
          end
        end
      end

      cpbp_pkg::CMD_RD: s_re = 1'b1;

      // slot record at cur_s is on rec
      cpbp_pkg::CMD_EVAL: begin
        unique case (op_r)
          cpbp_pkg::FN_RELEASE, cpbp_pkg::FN_NEW_REF: begin
            if (op_r == cpbp_pkg::FN_RELEASE) begin
              if (rec.refs != '0) begin
                nrefs = rec.refs - 1'b1;
                s_we  = 1'b1;
                s_wdata.refs = nrefs;
                if (nrefs == '0) begin
                  f_we  = 1'b1;
                  f_val = 1'b1;
                  if (unused_r < cpbp_pkg::CNT_W'(cpbp_pkg::SLOT_COUNT))
                    unused_nxt = unused_r + 1'b1;
                end
              end
            end else if (rec.refs != cpbp_pkg::REF_MAX) begin
              s_we = 1'b1;
              s_wdata.refs = rec.refs + 1'b1;
              f_we = 1'b1;
            end
            steps_nxt = steps_inc;
            cur_s_nxt = rec.link;
            if (cpbp_pkg::slot_real(rec.link) &&
                steps_inc < cpbp_pkg::CNT_W'(cpbp_pkg::SLOT_COUNT)) begin
              sts.more = 1'b1;
            end else if (op_r == cpbp_pkg::FN_RELEASE) begin
              d_we  = 1'b1;
              d_new = cpbp_pkg::DESC_RST;
            end else begin
              d_we  = 1'b1;
              d_idx = oc_r;
              d_new = '{head: dsc.head, ws: dsc.ws, rs: dsc.head, off: '0,
                        tot: dsc.tot};
            end
          end

          cpbp_pkg::FN_SEEK: begin
            if (cur_r_r < fill_x || !cpbp_pkg::slot_real(rec.link)) begin
              d_we      = 1'b1;
              d_new.rs  = cur_s_r;
              d_new.off = cur_r_r;
            end else begin
              cur_r_nxt = cur_r_r - fill_x;
              cur_s_nxt = rec.link;
              steps_nxt = steps_inc;
              if (steps_inc < cpbp_pkg::CNT_W'(cpbp_pkg::SLOT_COUNT)) sts.more = 1'b1;
              else begin
                d_we      = 1'b1;
                d_new.rs  = rec.link;
                d_new.off = cur_r_r - fill_x;
              end
            end
          end

          cpbp_pkg::FN_PUT: begin
            if ((fill_x >= BW'(cpbp_pkg::SLOT_SIZE)) || !cpbp_pkg::slot_real(dsc.head)) begin
              // chain needs a fresh slot first
              if (!ff_found) stat_nxt = cpbp_pkg::STS_FULL;
              else begin
                f_we  = 1'b1;
                f_idx = ff_idx;
                if (unused_r != '0) unused_nxt = unused_r - 1'b1;
                d_we     = 1'b1;
                d_new.ws = ff_slot;
                if (!cpbp_pkg::slot_real(dsc.head)) begin
                  d_new.head = ff_slot;
                  d_new.rs   = ff_slot;
                end
                d_new.tot = dsc.tot + 1'b1;
                b_we      = 1'b1;
                b_waddr   = cpbp_pkg::byte_addr(ff_slot, '0);
                s_we      = 1'b1;
                if (ff_slot == cur_s_r) begin
                  s_waddr = ff_idx;
                  s_wdata = '{refs: 8'd1, fill: 6'd1, link: ff_slot};
                end else begin
                  s_wdata.link = ff_slot;
                  w2_addr_nxt  = ff_idx;
                  w2_rec_nxt   = '{refs: 8'd1, fill: 6'd1, link: cpbp_pkg::NIL_SLOT};
                  sts.wr2      = 1'b1;
                end
              end
            end else begin
              b_we         = 1'b1;
              b_waddr      = cpbp_pkg::byte_addr(cur_s_r, fill_x);
              s_we         = 1'b1;
              s_wdata.fill = rec.fill + 1'b1;
              d_we         = 1'b1;
              d_new.tot    = dsc.tot + 1'b1;
            end
          end

          cpbp_pkg::FN_GET: begin
            if (!phase_r && cur_r_r >= fill_x && cpbp_pkg::slot_real(rec.link)) begin
              // read point sits at end of slot: hop to next
              cur_s_nxt = rec.link;
              cur_r_nxt = '0;
              phase_nxt = 1'b1;
              sts.more  = 1'b1;
            end else if (cur_r_r >= fill_x) begin
              stat_nxt = cpbp_pkg::STS_RANGE;
            end else begin
              sts.byte_rd = 1'b1;
              d_we        = 1'b1;
              d_new.rs    = cur_s_r;
              d_new.off   = cur_r_r + 1'b1;
            end
          end

          cpbp_pkg::FN_REMOVE_LAST: begin
            if (cpbp_pkg::slot_real(rec.link) &&
                steps_r < cpbp_pkg::CNT_W'(cpbp_pkg::SLOT_COUNT)) begin
              prev_s_nxt   = cur_s_r;
              prev_rec_nxt = rec;
              cur_s_nxt    = rec.link;
              steps_nxt    = steps_inc;
              sts.more     = 1'b1;
            end else if (rec.fill == '0) begin
              stat_nxt = cpbp_pkg::STS_RANGE;
            end else begin
              nfill = rec.fill - 1'b1;
              d_we  = 1'b1;
              if (dsc.tot != '0) d_new.tot = dsc.tot - 1'b1;
              s_we  = 1'b1;
              s_wdata.fill = nfill;
              if (nfill == '0 && prev_s_r != cur_s_r) begin
                // last slot emptied: unlink it and drop its reference
                if (rec.refs != '0) begin
                  nrefs = rec.refs - 1'b1;
                  s_wdata.refs = nrefs;
                  if (nrefs == '0) begin
                    f_we  = 1'b1;
                    f_val = 1'b1;
                    if (unused_r < cpbp_pkg::CNT_W'(cpbp_pkg::SLOT_COUNT))
                      unused_nxt = unused_r + 1'b1;
                  end
                end
                w2_addr_nxt = prev_s_r[IW-1:0];
                w2_rec_nxt  = '{refs: prev_rec_r.refs, fill: prev_rec_r.fill,
                                link: cpbp_pkg::NIL_SLOT};
                sts.wr2     = 1'b1;
                if (dsc.ws == cur_s_r) d_new.ws = prev_s_r;
                if (dsc.rs == cur_s_r) begin
                  d_new.rs  = prev_s_r;
                  d_new.off = BW'(prev_rec_r.fill);
                end
              end
            end
          end

          default: ;
        endcase
      end

      cpbp_pkg::CMD_BYTE: b_re = 1'b1;

      cpbp_pkg::CMD_WR2: begin
        s_we    = 1'b1;
        s_waddr = w2_addr_r;
        s_wdata = w2_rec_r;
      end

      // result word
      cpbp_pkg::CMD_OUT: begin
        out_nxt = '0;
        out_nxt[7:0]   = (op_r == cpbp_pkg::FN_GET && stat_r == cpbp_pkg::STS_OK) ?
                         b_rdata : '0;
        out_nxt[9:8]   = stat_r;
        out_nxt[17:10] = bad ? '0 : dsc.tot;
        out_nxt[24:18] = unused_r;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cpbp_pkg::CHAIN_COUNT; i++) desc_r[i] <= cpbp_pkg::DESC_RST;
      vld_r    <= '0;
      free_r   <= '1;
      unused_r <= cpbp_pkg::CNT_W'(cpbp_pkg::SLOT_COUNT);
    end else begin
      if (d_we) desc_r[d_idx] <= d_new;
      if (s_we) vld_r[s_waddr] <= 1'b1;
      if (f_we) free_r[f_idx] <= f_val;
      unused_r <= unused_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt; c_r <= c_nxt; oc_r <= oc_nxt; din_r <= din_nxt; pos_r <= pos_nxt;
    cur_s_r <= cur_s_nxt; prev_s_r <= prev_s_nxt; prev_rec_r <= prev_rec_nxt;
    cur_r_r <= cur_r_nxt; steps_r <= steps_nxt; phase_r <= phase_nxt;
    stat_r <= stat_nxt; w2_addr_r <= w2_addr_nxt; w2_rec_r <= w2_rec_nxt;
    out_r <= out_nxt;
    if (s_re) rd_vld_r <= vld_r[s_raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/chained_packet_buffer_pool_core.sv */
`default_nettype none
// An accepted word is decoded; new, reset and rejected words then load the result.
//   put adds an evaluation (and a record write to link a fresh slot); get adds an
//   evaluation and byte read (after a hop at a slot end). release, new_ref, seek and
//   remove_last walk the chain, one read and evaluation per slot (and a record write
//   when remove_last unlinks its emptied last slot). One word is in flight; the next
//   is taken in the cycle after a result load; a held result stalls that load.
// Reset (rst_n low, synchronous) empties all descriptors and frees all slots
//   at once via per-slot valid bits; no clearing pass. Byte storage is not reset.
// ----------------------------------------------------------------------------
// chained_packet_buffer_pool_core
// Reference counted packet buffer pool with linked slot chains.
// ----------------------------------------------------------------------------
module chained_packet_buffer_pool_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // func[2:0], chain[6:3], other_chain[10:7], data_in[18:11], position[26:19]
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // data_out[7:0], status[9:8], chain_bytes[17:10], free_count[24:18]
  output logic [31:0]      out_tdata
);

  cpbp_pkg::cmd_t    cmd;
  cpbp_pkg::dp_sts_t sts;

  cpbp_ctl u_ctl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .cmd(cmd)
  );

  cpbp_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .cmd(cmd), .sts(sts), .out_tdata(out_tdata)
  );

  // accepted word is decoded on the next cycle
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> cmd == cpbp_pkg::CMD_EXEC)
    else $error("accepted word not decoded");

  // result load raises valid
  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == cpbp_pkg::CMD_OUT |=> out_tvalid)
    else $error("result loaded without valid");

  // every slot read is followed by its evaluation
  a_eval_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == cpbp_pkg::CMD_RD |=> cmd == cpbp_pkg::CMD_EVAL)
    else $error("slot read not evaluated");

endmodule
`default_nettype wire
